[design/crc32de_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32de_pkg
// Shared constants, types and the byte update function of the CRC-32 engine.
// ----------------------------------------------------------------------------
package crc32de_pkg;

  localparam logic [31:0] CRC_POLY_STD = 32'hEDB8_8320;
  localparam logic [31:0] CRC_POLY_ALT = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;

  // per-byte framing flags
  typedef struct packed {
    logic first;
    logic last;
  } byte_ctrl_t;

  // right-shifting update: xor byte into the low bits, then eight shift steps
  function automatic logic [31:0] crc_byte_update(
    input logic [31:0] crc_in,
    input logic [7:0]  data,
    input logic [31:0] poly
  );
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/crc32de_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32de_core
// Running CRC register and the one-byte update feeding it.
// ----------------------------------------------------------------------------
module crc32de_core
  import crc32de_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,        // staged byte is consumed this cycle
  input  logic [7:0]  data_byte,
  input  byte_ctrl_t  ctrl,
  input  logic        poly_sel,
  output logic [31:0] crc_final   // inverted crc through the staged byte
);

  logic [31:0] running_r;
  logic [31:0] running_nxt;
  logic [31:0] crc_upd;
  logic [31:0] crc_start;
  logic [31:0] poly;

  assign poly      = poly_sel ? CRC_POLY_STD : CRC_POLY_ALT;
  assign crc_start = ctrl.first ? CRC_INIT : running_r;
  assign crc_upd   = crc_byte_update(crc_start, data_byte, poly);
  assign crc_final = ~crc_upd;

  always_comb begin
    running_nxt = running_r;
    if (adv) begin
      // reload after the last byte so the next message starts fresh
      running_nxt = ctrl.last ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= CRC_INIT;
    end else begin
      running_r <= running_nxt;
    end
  end

endmodule

[design/crc32_byte_engine_dual_poly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_byte_engine_dual_poly
// Byte-wide reflected CRC-32 with a register-selected polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per transaction; in_tuser marks the first byte
//           (crc restarts at all ones), in_tlast marks the last byte.
//   out_* : one transaction per message, carrying the inverted CRC.
//   APB   : register 0 at address 0, poly_select (1 = 0xEDB88320,
//           0 = 0x04C11DB7 shifted right); write only while idle.
// Timing:
//   an accepted byte is registered in the input stage, where the update is
//   done; for a last byte the result is then registered into the output
//   register and held on out_tdata until taken. One byte per cycle
//   sustained unless a last byte is held by a stalled output, set by the
//   combinational eight-step xor update into the running crc register.
// Reset:
//   running crc goes to all ones, poly_select to 1, both stages empty.
// Stall:
//   while out_tready is low and a result waits, a last byte held in the
//   input stage stays put and in_tready drops; non-last bytes keep flowing.
// ----------------------------------------------------------------------------
module crc32_byte_engine_dual_poly
  import crc32de_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] crc_value
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        stg_vld_r;
  logic        stg_vld_nxt;
  logic [7:0]  stg_data_r;
  byte_ctrl_t  stg_ctrl_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [31:0] out_data_r;
  logic        poly_sel_r;
  logic        stg_adv;
  logic        in_acc;
  logic        cfg_wr;
  logic [31:0] crc_final;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, poly_sel_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_sel_r <= 1'b1;
    end else if (cfg_wr) begin
      poly_sel_r <= pwdata[0];
    end
  end

  // ---------------- input stage ----------------
  // a last byte needs a free output slot; other bytes never wait
  assign stg_adv   = stg_vld_r && (!stg_ctrl_r.last || !out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || stg_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_data_r       <= in_tdata;
      stg_ctrl_r.first <= in_tuser;
      stg_ctrl_r.last  <= in_tlast;
    end
  end

  crc32de_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (stg_adv),
    .data_byte (stg_data_r),
    .ctrl      (stg_ctrl_r),
    .poly_sel  (poly_sel_r),
    .crc_final (crc_final)
  );

  // ---------------- output register ----------------
  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (stg_adv && stg_ctrl_r.last) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_ctrl_r.last) begin
      out_data_r <= crc_final;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  a_last_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && stg_ctrl_r.last |=> out_vld_r && (out_data_r == $past(crc_final)))
    else $error("last byte did not load the result register");

  a_held_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && stg_ctrl_r.last && out_vld_r && !out_tready |-> !in_tready)
    else $error("input accepted while a last byte is blocked");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !stg_adv |=> stg_vld_r && $stable(stg_data_r))
    else $error("staged byte lost while stalled");

endmodule
